// File: rtl/positional_list_insert_delete_search_unit_defines.svh
// assertion macros for the positional list checker
`ifndef POSITIONAL_LIST_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_SEARCH_UNIT_DEFINES_SVH

// clocked assertion, disabled while reset is high
`define PLIST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PLIST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/plist_pkg.sv
// shared types and constants of the positional list unit
`default_nettype none

package plist_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_DELETE  = 3'd1;
   localparam logic [2:0] OP_REPLACE = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_INSERT  = 2'd1,
      CMD_DELETE  = 2'd2,
      CMD_REPLACE = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]             opcode;
      logic [POS_W-1:0]       position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    found;
      logic [3:0]              found_index;
      logic signed [VAL_W-1:0] read_value;
      logic [4:0]              entry_count;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] slot;
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/plist_cell.sv
// one slot of the list: holds an entry, shifts with its neighbors, compares
`default_nettype none

module plist_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [plist_pkg::IDX_W-1:0]   idx,
   input  wire plist_pkg::cmd_type            cmd,
   input  wire logic [plist_pkg::VAL_W-1:0]   left_entry,
   input  wire logic [plist_pkg::VAL_W-1:0]   right_entry,
   output logic      [plist_pkg::VAL_W-1:0]   entry,
   output logic                               hit
);

   logic [plist_pkg::VAL_W-1:0] entry_ff, entry_in;
   logic [plist_pkg::CNT_W-1:0] idx_c;

   assign idx_c = plist_pkg::CNT_W'(idx);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         plist_pkg::CMD_INSERT: begin
            if (idx == cmd.slot) begin
               entry_in = cmd.value;
            end else if (idx > cmd.slot && idx_c <= cmd.count) begin
               entry_in = left_entry;
            end
         end
         plist_pkg::CMD_DELETE: begin
            // last occupied slot falls vacant and is cleared
            if (idx_c + plist_pkg::CNT_W'(1) == cmd.count) begin
               entry_in = '0;
            end else if (idx >= cmd.slot && idx_c + plist_pkg::CNT_W'(1) < cmd.count) begin
               entry_in = right_entry;
            end
         end
         plist_pkg::CMD_REPLACE: begin
            if (idx == cmd.slot) begin
               entry_in = cmd.value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = (idx_c < cmd.count) && (entry_ff == cmd.value);

endmodule

`default_nettype wire

// File: rtl/positional_list_insert_delete_search_unit.sv
// top level of the positional list: cell chain, operation decode, result register
//
//   channel   dir  handshake              payload
//   req_      in   req_valid / req_ready  plist_pkg::req_type
//   rsp_      out  rsp_valid / rsp_ready  plist_pkg::rsp_type
//
// all cells shift, write or compare at once for each operation
// the result is registered and shows in the cycle after the item is accepted
// a new item is taken while the result register is empty or being drained
// synchronous reset clears every entry, the count and the result valid
// a stalled result holds the input side once the result register is full
`default_nettype none

module positional_list_insert_delete_search_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire plist_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output plist_pkg::rsp_type      rsp_data
);

   localparam int DEPTH = plist_pkg::DEPTH;
   localparam int IDX_W = plist_pkg::IDX_W;
   localparam int CNT_W = plist_pkg::CNT_W;
   localparam int POS_W = plist_pkg::POS_W;
   localparam int VAL_W = plist_pkg::VAL_W;
   localparam int CMP_W = plist_pkg::CMP_W;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   plist_pkg::rsp_type rsp_ff, rsp_in;
   plist_pkg::cmd_type cmd;

   logic [VAL_W-1:0] entries   [DEPTH];
   logic [VAL_W-1:0] left_arr  [DEPTH];
   logic [VAL_W-1:0] right_arr [DEPTH];
   logic [DEPTH-1:0] hits;

   logic             accept;
   logic [CMP_W-1:0] pos_x, n_x;
   logic             in_list, ins_ok, full;
   logic [IDX_W-1:0] slot;
   logic             any_hit;
   logic [IDX_W-1:0] hit_idx;

   genvar k;
   generate
      for (k = 0; k < DEPTH; k++) begin : g_cell
         if (k == 0) begin : g_first
            assign left_arr[k] = '0;
         end else begin : g_left
            assign left_arr[k] = entries[k-1];
         end
         if (k == DEPTH - 1) begin : g_last
            assign right_arr[k] = '0;
         end else begin : g_right
            assign right_arr[k] = entries[k+1];
         end
         plist_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .idx         (IDX_W'(k)),
            .cmd         (cmd),
            .left_entry  (left_arr[k]),
            .right_entry (right_arr[k]),
            .entry       (entries[k]),
            .hit         (hits[k])
         );
      end
   endgenerate

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_x   = CMP_W'(req_data.position);
   assign n_x     = CMP_W'(count_ff);
   assign in_list = (pos_x != '0) && (pos_x <= n_x);
   assign ins_ok  = (pos_x != '0) && (pos_x <= n_x + CMP_W'(1));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign slot    = IDX_W'(req_data.position - POS_W'(1));

   // first match wins: scan from the top so the lowest index is kept
   always_comb begin
      any_hit = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hits[i]) begin
            any_hit = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      cmd.kind  = plist_pkg::CMD_NONE;
      cmd.slot  = slot;
      cmd.count = count_ff;
      cmd.value = req_data.value;
      count_in  = count_ff;
      rsp_in.status      = plist_pkg::ST_OK;
      rsp_in.found       = 1'b0;
      rsp_in.found_index = '0;
      rsp_in.read_value  = '0;
      case (req_data.opcode)
         plist_pkg::OP_INSERT: begin
            if (full) begin
               rsp_in.status = plist_pkg::ST_FULL;
            end else if (!ins_ok) begin
               rsp_in.status = plist_pkg::ST_RANGE;
            end else begin
               cmd.kind = plist_pkg::CMD_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         plist_pkg::OP_DELETE: begin
            if (!in_list) begin
               rsp_in.status = plist_pkg::ST_RANGE;
            end else begin
               cmd.kind = plist_pkg::CMD_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         plist_pkg::OP_REPLACE: begin
            if (!in_list) begin
               rsp_in.status = plist_pkg::ST_RANGE;
            end else begin
               cmd.kind = plist_pkg::CMD_REPLACE;
            end
         end
         plist_pkg::OP_SEARCH: begin
            rsp_in.found       = any_hit;
            rsp_in.found_index = 4'(hit_idx);
         end
         plist_pkg::OP_READ: begin
            if (!in_list) begin
               rsp_in.status = plist_pkg::ST_RANGE;
            end else begin
               rsp_in.read_value = entries[slot];
            end
         end
         default: begin
            rsp_in.status = plist_pkg::ST_RANGE;
         end
      endcase
      rsp_in.entry_count = 5'(count_in);
      if (!accept) begin
         cmd.kind = plist_pkg::CMD_NONE;
         count_in = count_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/plist_checker.sv
// port-level checks on the positional list unit, bound to the top level
`default_nettype none

`include "positional_list_insert_delete_search_unit_defines.svh"

module plist_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire plist_pkg::rsp_type rsp_data
);

   // a result waiting to be taken stays
   `PLIST_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // every accepted item gives a result in the next cycle
   `PLIST_ASSERT(a_item_result, req_valid && req_ready |=> rsp_valid, "accepted item gave no result")

   // a match is always an ok search result inside the list
   `PLIST_ASSERT(a_found_ok, rsp_valid && rsp_data.found |-> rsp_data.status == plist_pkg::ST_OK && 5'(rsp_data.found_index) < rsp_data.entry_count, "match outside the list")

   // the count never exceeds the list size
   `PLIST_ASSERT(a_count_max, rsp_valid |-> rsp_data.entry_count <= 5'(plist_pkg::DEPTH), "entry count over depth")

   // no result is shown in the cycle after a reset cycle
   `PLIST_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind positional_list_insert_delete_search_unit plist_checker u_plist_checker (.*);

`default_nettype wire

// File: tb/sv/positional_list_insert_delete_search_unit_tb.sv
// self-checking testbench for the positional list unit: shadow list, random traffic, stalls
`timescale 1ns / 1ps

// shadow copy of the list; predicts each result and checks what comes back
class list_mirror;
   bit signed [31:0]    entries [plist_pkg::DEPTH];
   int                  used = 0;
   int                  errors = 0;
   plist_pkg::rsp_type  pending_results [$];

   // apply one accepted item to the shadow list and queue its result
   function void note_request(plist_pkg::req_type item);
      plist_pkg::rsp_type outcome;
      int n;
      int p;
      outcome = '0;
      n = used;
      p = int'(item.position);
      case (item.opcode)
         plist_pkg::OP_INSERT: begin
            // full is checked before the position
            if (n >= plist_pkg::DEPTH) begin
               outcome.status = plist_pkg::ST_FULL;
            end else if (p < 1 || p > n + 1) begin
               outcome.status = plist_pkg::ST_RANGE;
            end else begin
               for (int k = n; k >= p; k--) entries[k] = entries[k-1];
               entries[p-1] = item.value;
               n++;
            end
         end
         plist_pkg::OP_DELETE: begin
            if (p < 1 || p > n) begin
               outcome.status = plist_pkg::ST_RANGE;
            end else begin
               for (int k = p - 1; k + 1 < n; k++) entries[k] = entries[k+1];
               entries[n-1] = '0;
               n--;
            end
         end
         plist_pkg::OP_REPLACE: begin
            if (p < 1 || p > n) outcome.status = plist_pkg::ST_RANGE;
            else entries[p-1] = item.value;
         end
         plist_pkg::OP_SEARCH: begin
            for (int k = n - 1; k >= 0; k--) begin
               if (entries[k] == item.value) begin
                  outcome.found = 1'b1;
                  outcome.found_index = 4'(k);
               end
            end
         end
         plist_pkg::OP_READ: begin
            if (p < 1 || p > n) outcome.status = plist_pkg::ST_RANGE;
            else outcome.read_value = entries[p-1];
         end
         default: outcome.status = plist_pkg::ST_RANGE;
      endcase
      used = n;
      outcome.entry_count = 5'(n);
      pending_results.push_back(outcome);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, seen);
         errors++;
      end
   endfunction

   function void check_result(plist_pkg::rsp_type seen);
      plist_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("result item with nothing expected: 0x%0h", seen);
         errors++;
      end else begin
         want = pending_results.pop_front();
         compare_field("status", 32'(want.status), 32'(seen.status));
         compare_field("found", 32'(want.found), 32'(seen.found));
         compare_field("found_index", 32'(want.found_index), 32'(seen.found_index));
         compare_field("read_value", want.read_value, seen.read_value);
         compare_field("entry_count", 32'(want.entry_count), 32'(seen.entry_count));
      end
   endfunction
endclass

module positional_list_insert_delete_search_unit_tb;

   localparam int STUCK_LIMIT     = 2000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES     = 10;
   localparam int RANDOM_ITEMS    = 1500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   plist_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   plist_pkg::rsp_type rsp_data;

   list_mirror tracker = new();
   bit         burst_mode = 1'b0;
   bit         rsp_hold_req = 1'b0;
   bit         grow = 1'b1;
   int         stuck_cycles = 0;

   positional_list_insert_delete_search_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic plist_pkg::req_type mk(logic [2:0] op, int pos, logic [31:0] v);
      plist_pkg::req_type item;
      item.opcode   = op;
      item.position = 5'(pos);
      item.value    = v;
      return item;
   endfunction

   // values often taken from the list so that searches hit
   function automatic logic [31:0] pick_value(int n);
      int r;
      r = $urandom_range(0, 99);
      if (n > 0 && r < 40) return tracker.entries[$urandom_range(0, n - 1)];
      if (r < 55) begin
         case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   // mostly legal operations on the current list, with some noise
   function automatic plist_pkg::req_type make_item();
      plist_pkg::req_type item;
      int n;
      int pick;
      n = tracker.used;
      if (n == 0) grow = 1'b1;
      else if (n == plist_pkg::DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if ($urandom_range(0, 59) == 0) grow = !grow;
      item.value = pick_value(n);
      if ($urandom_range(0, 99) < 8) begin
         item.opcode   = 3'($urandom_range(0, 7));
         item.position = 5'($urandom_range(0, 31));
         return item;
      end
      pick = $urandom_range(0, 99);
      if (grow) begin
         if (pick < 50) item.opcode = plist_pkg::OP_INSERT;
         else if (pick < 60) item.opcode = plist_pkg::OP_DELETE;
         else if (pick < 70) item.opcode = plist_pkg::OP_REPLACE;
         else if (pick < 85) item.opcode = plist_pkg::OP_SEARCH;
         else item.opcode = plist_pkg::OP_READ;
      end else begin
         if (pick < 15) item.opcode = plist_pkg::OP_INSERT;
         else if (pick < 55) item.opcode = plist_pkg::OP_DELETE;
         else if (pick < 65) item.opcode = plist_pkg::OP_REPLACE;
         else if (pick < 80) item.opcode = plist_pkg::OP_SEARCH;
         else item.opcode = plist_pkg::OP_READ;
      end
      if (item.opcode == plist_pkg::OP_INSERT) item.position = 5'($urandom_range(1, n + 1));
      else if (n == 0) item.position = 5'd1;
      else item.position = 5'($urandom_range(1, n));
      return item;
   endfunction

   // returns at the falling edge where the next item goes out
   task automatic start_slot();
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
   endtask

   task automatic present(plist_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic issue(plist_pkg::req_type item);
      start_slot();
      present(item);
   endtask

   task automatic drain_wait();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
   endtask

   // result side: random back-pressure, one long hold on request
   initial begin
      int r;
      wait (!reset);
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (burst_mode || r < 65) begin
            rsp_ready <= 1'b1;
         end else if (r < 95) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end
      end
   end

   // results are checked before the item taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_data);
         if (req_valid && req_ready) tracker.note_request(req_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("** positional_list_insert_delete_search_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] v;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty list: everything positional is out of range, search misses zero
      issue(mk(plist_pkg::OP_READ, 1, 0));
      issue(mk(plist_pkg::OP_DELETE, 1, 0));
      issue(mk(plist_pkg::OP_SEARCH, 0, 0));
      issue(mk(plist_pkg::OP_INSERT, 2, 5));
      for (int c = plist_pkg::OP_READ + 1; c < 8; c++) issue(mk(3'(c), 1, 0));

      // fill to the top with inserts at the front and in the middle
      for (int k = 0; k < plist_pkg::DEPTH; k++) begin
         if (k == 0) v = 32'h7fff_ffff;
         else if (k == 1) v = 32'h8000_0000;
         else if (k < 4) v = 32'h0;
         else v = $urandom;
         issue(mk(plist_pkg::OP_INSERT, k / 2 + 1, v));
      end
      issue(mk(plist_pkg::OP_INSERT, 31, 1));
      issue(mk(plist_pkg::OP_SEARCH, 31, 0));
      issue(mk(plist_pkg::OP_READ, plist_pkg::DEPTH, 0));
      issue(mk(plist_pkg::OP_REPLACE, plist_pkg::DEPTH + 1, 7));
      issue(mk(plist_pkg::OP_REPLACE, 1, 32'hffff_ffff));
      issue(mk(plist_pkg::OP_DELETE, 1, 0));
      drain_wait();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         if (i == 400) begin
            burst_mode   = 1'b1;
            rsp_hold_req = 1'b1;
         end
         if (i == 900) drain_wait();
         start_slot();
         present(make_item());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() != 0) begin
         $error("%0d result items never arrived", tracker.pending_results.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("** positional_list_insert_delete_search_unit: PASSED **");
      end else begin
         $display("** positional_list_insert_delete_search_unit: FAILED **");
      end
      $finish;
   end

endmodule
